// ===== rtl/icle_pkg.sv =====
`timescale 1ns / 1ps

package icle_pkg;

   localparam int DELTA_WIDTH_DEFAULT = 32;
   localparam int BYTES_WIDTH = 17;
   localparam logic [BYTES_WIDTH-1:0] BYTES_MAX = 17'h1FFFF;
   localparam logic [15:0] LOG_LIMIT_RESET = 16'd4096;
   localparam int GROUP_BITS = 7;
   localparam logic [7:0] CONT_FLAG = 8'h80;

   // micro-op codes
   localparam logic [2:0] OP_ACCEPT = 3'd0;
   localparam logic [2:0] OP_VARINT = 3'd1;
   localparam logic [2:0] OP_MASK   = 3'd2;
   localparam logic [2:0] OP_TALLY  = 3'd3;
   localparam logic [2:0] OP_CHECK  = 3'd4;

   // jump conditions
   localparam logic [1:0] COND_NEVER    = 2'd0;
   localparam logic [1:0] COND_ALWAYS   = 2'd1;
   localparam logic [1:0] COND_NO_EVENT = 2'd2;
   localparam logic [1:0] COND_MORE     = 2'd3;

   localparam int STEP_WIDTH = 3;
   localparam logic [STEP_WIDTH-1:0] STEP_ACCEPT = 3'd0;
   localparam logic [STEP_WIDTH-1:0] STEP_VARINT = 3'd1;
   localparam logic [STEP_WIDTH-1:0] STEP_MASK   = 3'd2;
   localparam logic [STEP_WIDTH-1:0] STEP_TALLY  = 3'd3;
   localparam logic [STEP_WIDTH-1:0] STEP_CHECK  = 3'd4;
   localparam logic [STEP_WIDTH-1:0] STEP_LAST   = STEP_CHECK;

   typedef struct packed {
      logic [2:0]            op;
      logic [1:0]            cond;
      logic [STEP_WIDTH-1:0] target;
   } ctrl_word_type;

   // control store
   function automatic ctrl_word_type ucode_rom(input logic [STEP_WIDTH-1:0] step);
      ctrl_word_type w;
      case (step)
         STEP_ACCEPT: w = '{op: OP_ACCEPT, cond: COND_NO_EVENT, target: STEP_TALLY};
         STEP_VARINT: w = '{op: OP_VARINT, cond: COND_MORE,     target: STEP_VARINT};
         STEP_MASK:   w = '{op: OP_MASK,   cond: COND_NEVER,    target: STEP_ACCEPT};
         STEP_TALLY:  w = '{op: OP_TALLY,  cond: COND_NEVER,    target: STEP_ACCEPT};
         STEP_CHECK:  w = '{op: OP_CHECK,  cond: COND_ALWAYS,   target: STEP_ACCEPT};
         default:     w = '{op: OP_CHECK,  cond: COND_ALWAYS,   target: STEP_ACCEPT};
      endcase
      return w;
   endfunction

endpackage

// ===== rtl/icle_if.sv =====
`timescale 1ns / 1ps

interface icle_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] input_bits;
   logic       new_run;
   modport source (output valid, output input_bits, output new_run, input ready);
   modport sink   (input valid, input input_bits, input new_run, output ready);
endinterface

interface icle_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] log_byte;
   logic       last_of_event;
   modport source (output valid, output log_byte, output last_of_event, input ready);
   modport sink   (input valid, input log_byte, input last_of_event, output ready);
endinterface

interface icle_csr_if;
   logic        valid;
   logic        ready;
   logic [15:0] log_limit;
   modport source (output valid, output log_limit, input ready);
   modport sink   (input valid, input log_limit, output ready);
endinterface

// ===== rtl/input_change_log_encoder_unit.sv =====
`timescale 1ns / 1ps

// Change log encoder: one item per tick carries an action mask; each logged event comes out
// as an unsigned LEB128 tick delta followed by the mask byte (last_of_event marks it). A small
// microcoded sequencer runs one control word per cycle, holding at accept until a tick arrives
// and at an output step while the single output register is full: accept, one step per output
// byte, then a byte tally and a limit check; a tick that logs nothing skips the output steps.
// The next tick is taken only when the sequencer is back at its accept step. log_limit may be
// written at any time.
module input_change_log_encoder_unit #(
   parameter int DELTA_WIDTH = icle_pkg::DELTA_WIDTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   icle_req_if.sink   req_chan,
   icle_rsp_if.source rsp_chan,
   icle_csr_if.sink   csr_chan
);

   localparam int MAX_BYTES = (DELTA_WIDTH + icle_pkg::GROUP_BITS - 1) / icle_pkg::GROUP_BITS + 1;
   localparam int CNT_W = $clog2(MAX_BYTES + 1);
   localparam int BW = icle_pkg::BYTES_WIDTH;

   logic [icle_pkg::STEP_WIDTH-1:0] pc_ff, pc_in;
   logic [DELTA_WIDTH-1:0] ticks_ff, ticks_in;
   logic [DELTA_WIDTH-1:0] delta_ff, delta_in;
   logic [7:0]    last_mask_ff, last_mask_in;
   logic [BW-1:0] bytes_ff, bytes_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic          recording_ff, recording_in;
   logic          awaiting_ff, awaiting_in;
   logic [15:0]   limit_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [7:0]    rsp_byte_ff, rsp_byte_in;
   logic          rsp_last_ff, rsp_last_in;

   icle_pkg::ctrl_word_type cw;
   logic slot_free, req_fire, hold, event_now, more, taken;
   logic rec_eff, seed_eff;
   logic [7:0] lm_eff;
   logic [DELTA_WIDTH-1:0] ticks_eff, ticks_inc;
   logic [BW:0] tally;

   assign cw        = icle_pkg::ucode_rom(pc_ff);
   assign slot_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (cw.op == icle_pkg::OP_ACCEPT);
   assign req_fire  = req_chan.valid && req_chan.ready;
   assign more      = |delta_ff[DELTA_WIDTH-1:icle_pkg::GROUP_BITS];

   // new run overrides the stored run state on the accepting tick
   assign rec_eff   = req_chan.new_run || recording_ff;
   assign seed_eff  = req_chan.new_run || awaiting_ff;
   assign lm_eff    = req_chan.new_run ? 8'd0 : last_mask_ff;
   assign ticks_eff = req_chan.new_run ? '0 : ticks_ff;
   assign ticks_inc = (&ticks_eff) ? ticks_eff : ticks_eff + 1'b1;
   assign event_now = rec_eff && (seed_eff || (req_chan.input_bits != lm_eff));
   assign tally     = {1'b0, bytes_ff} + (BW + 1)'(count_ff);

   always_comb begin
      hold = 1'b0;
      case (cw.op)
         icle_pkg::OP_ACCEPT: hold = !req_fire;
         icle_pkg::OP_VARINT,
         icle_pkg::OP_MASK:   hold = !slot_free;
         default:             hold = 1'b0;
      endcase
      taken = 1'b0;
      case (cw.cond)
         icle_pkg::COND_NEVER:    taken = 1'b0;
         icle_pkg::COND_ALWAYS:   taken = 1'b1;
         icle_pkg::COND_NO_EVENT: taken = !event_now;
         icle_pkg::COND_MORE:     taken = more;
         default:                 taken = 1'b0;
      endcase
      if (hold) begin
         pc_in = pc_ff;
      end else if (taken) begin
         pc_in = cw.target;
      end else begin
         pc_in = pc_ff + 1'b1;
      end
   end

   always_comb begin
      ticks_in     = ticks_ff;
      delta_in     = delta_ff;
      last_mask_in = last_mask_ff;
      bytes_in     = bytes_ff;
      count_in     = count_ff;
      recording_in = recording_ff;
      awaiting_in  = awaiting_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_byte_in  = rsp_byte_ff;
      rsp_last_in  = rsp_last_ff;
      case (cw.op)
         icle_pkg::OP_ACCEPT: begin
            if (req_fire) begin
               count_in = '0;
               if (req_chan.new_run) begin
                  bytes_in     = '0;
                  recording_in = 1'b1;
                  awaiting_in  = 1'b1;
                  ticks_in     = '0;
                  last_mask_in = 8'd0;
               end
               if (rec_eff) begin
                  if (seed_eff) begin
                     awaiting_in  = 1'b0;
                     ticks_in     = '0;
                     delta_in     = '0;
                     last_mask_in = req_chan.input_bits;
                  end else if (req_chan.input_bits != lm_eff) begin
                     delta_in     = ticks_inc;
                     ticks_in     = '0;
                     last_mask_in = req_chan.input_bits;
                  end else begin
                     ticks_in = ticks_inc;
                  end
               end
            end
         end
         icle_pkg::OP_VARINT: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = {more, delta_ff[icle_pkg::GROUP_BITS-1:0]};
               rsp_last_in  = 1'b0;
               delta_in     = delta_ff >> icle_pkg::GROUP_BITS;
               count_in     = count_ff + 1'b1;
            end
         end
         icle_pkg::OP_MASK: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = last_mask_ff;
               rsp_last_in  = 1'b1;
               count_in     = count_ff + 1'b1;
            end
         end
         icle_pkg::OP_TALLY: begin
            bytes_in = (tally > {1'b0, icle_pkg::BYTES_MAX}) ? icle_pkg::BYTES_MAX : tally[BW-1:0];
         end
         icle_pkg::OP_CHECK: begin
            if (bytes_ff > {{(BW - 16){1'b0}}, limit_ff}) begin
               recording_in = 1'b0;
            end
         end
         default: begin
            recording_in = recording_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= icle_pkg::STEP_ACCEPT;
         ticks_ff     <= '0;
         last_mask_ff <= 8'd0;
         bytes_ff     <= '0;
         recording_ff <= 1'b1;
         awaiting_ff  <= 1'b1;
         limit_ff     <= icle_pkg::LOG_LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff        <= pc_in;
         ticks_ff     <= ticks_in;
         last_mask_ff <= last_mask_in;
         bytes_ff     <= bytes_in;
         recording_ff <= recording_in;
         awaiting_ff  <= awaiting_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_chan.valid) begin
            limit_ff <= csr_chan.log_limit;
         end
      end
   end

   always_ff @(posedge clock) begin
      delta_ff    <= delta_in;
      count_ff    <= count_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign csr_chan.ready         = 1'b1;
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.log_byte      = rsp_byte_ff;
   assign rsp_chan.last_of_event = rsp_last_ff;

   a_pc_range: assert property (@(posedge clock) disable iff (reset)
      pc_ff <= icle_pkg::STEP_LAST)
      else $error("sequencer step out of range");

   a_emit_stall: assert property (@(posedge clock) disable iff (reset)
      ((pc_ff == icle_pkg::STEP_VARINT || pc_ff == icle_pkg::STEP_MASK)
       && rsp_valid_ff && !rsp_chan.ready) |=> $stable(pc_ff))
      else $error("sequencer advanced over a full output register");

   a_seed_emits: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_chan.new_run) |=> (pc_ff == icle_pkg::STEP_VARINT))
      else $error("new run did not start a seed event");

   a_bytes_cap: assert property (@(posedge clock) disable iff (reset)
      bytes_ff <= icle_pkg::BYTES_MAX)
      else $error("byte count beyond its cap");

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

   localparam int DELTA_W = icle_pkg::DELTA_WIDTH_DEFAULT;
   localparam logic [7:0] GROUP_MASK = 8'h7F;
   localparam logic [2:0] NO_LIT = 3'd7;
   localparam int IDLE_PCT = 23;
   localparam int DRAIN_CYCLES = 12;
   localparam int ITEMS_PER_PHASE = 28;

   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } log_item_type;

   // one directed row; lit holds the expected bytes, first byte in the top bits
   typedef struct packed {
      logic [7:0]  mask;
      logic        new_run;
      logic [15:0] reps;
      logic [2:0]  lit_n;
      logic [31:0] lit;
   } tick_row_type;

   logic clock;
   logic reset;

   icle_req_if req_bus ();
   icle_rsp_if rsp_bus ();
   icle_csr_if csr_bus ();

   input_change_log_encoder_unit i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus),
      .csr_chan (csr_bus)
   );

   // encoder state as the block should hold it
   logic [7:0]                       p_last_mask;
   logic [DELTA_W-1:0]               p_ticks;
   logic [icle_pkg::BYTES_WIDTH-1:0] p_bytes;
   logic                             p_recording;
   logic                             p_awaiting_seed;
   logic [15:0]                      p_limit;

   log_item_type tick_bytes[$];
   log_item_type pending_log[$];
   tick_row_type dir_rows[$];
   log_item_type head_item;
   int           errors = 0;
   logic         steady = 1'b0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic void log_event(input logic [63:0] delta, input logic [7:0] m);
      log_item_type b;
      while (delta >= 64'h80) begin
         b.data = icle_pkg::CONT_FLAG | (delta[7:0] & GROUP_MASK);
         b.last = 1'b0;
         tick_bytes.insert(tick_bytes.size(), b);
         delta = delta >> icle_pkg::GROUP_BITS;
      end
      b.data = delta[7:0] & GROUP_MASK;
      b.last = 1'b0;
      tick_bytes.insert(tick_bytes.size(), b);
      b.data = m;
      b.last = 1'b1;
      tick_bytes.insert(tick_bytes.size(), b);
   endfunction

   function automatic void encode_tick(input logic [7:0] m, input logic nr);
      int total;
      tick_bytes.delete();
      if (nr) begin
         p_last_mask = 8'h00;
         p_ticks = '0;
         p_bytes = '0;
         p_recording = 1'b1;
         p_awaiting_seed = 1'b1;
      end
      if (!p_recording) return;
      if (p_awaiting_seed) begin
         p_awaiting_seed = 1'b0;
         p_ticks = '0;
         p_last_mask = m;
         log_event(64'd0, m);
      end else begin
         if (p_ticks != '1) p_ticks = p_ticks + 1'b1;
         if (m != p_last_mask) begin
            log_event(64'(p_ticks), m);
            p_ticks = '0;
            p_last_mask = m;
         end
      end
      total = int'(p_bytes) + tick_bytes.size();
      if (total > int'(icle_pkg::BYTES_MAX)) p_bytes = icle_pkg::BYTES_MAX;
      else p_bytes = total[icle_pkg::BYTES_WIDTH-1:0];
      if (p_bytes > p_limit) p_recording = 1'b0;
   endfunction

   function automatic void add_row(input logic [7:0] m, input logic nr, input int reps,
                                   input logic [2:0] n, input logic [31:0] lit);
      tick_row_type row;
      row.mask = m;
      row.new_run = nr;
      row.reps = reps[15:0];
      row.lit_n = n;
      row.lit = lit;
      dir_rows.insert(dir_rows.size(), row);
   endfunction

   // enter and leave at a falling edge
   task automatic send_tick(input logic [7:0] m, input logic nr, input logic [2:0] lit_n,
                            input logic [31:0] lit);
      int k;
      log_item_type item;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid = 1'b1;
      req_bus.input_bits = m;
      req_bus.new_run = nr;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      encode_tick(m, nr);
      if (lit_n == NO_LIT) begin
         foreach (tick_bytes[j]) pending_log.insert(pending_log.size(), tick_bytes[j]);
      end else begin
         for (k = 0; k < lit_n; k++) begin
            item.data = lit[31-8*k -: 8];
            item.last = (k == lit_n - 1);
            pending_log.insert(pending_log.size(), item);
         end
      end
      @(negedge clock);
      req_bus.valid = 1'b0;
   endtask

   // hold until every expected byte is out, then let the sequencer settle
   task automatic wait_drained();
      while (pending_log.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic write_log_limit(input logic [15:0] value);
      csr_bus.valid = 1'b1;
      csr_bus.log_limit = value;
      do @(posedge clock); while (!(csr_bus.valid && csr_bus.ready));
      p_limit = value;
      @(negedge clock);
      csr_bus.valid = 1'b0;
   endtask

   task automatic run_random_ticks(input int target);
      int counted;
      int len;
      int pick;
      logic [7:0] m;
      logic nr;
      counted = 0;
      while (counted < target) begin
         pick = $urandom_range(99);
         if (pick < 4) begin
            // hold the current mask for a stretch so the delta grows
            len = $urandom_range(12, 4);
            repeat (len) send_tick(p_last_mask, 1'b0, NO_LIT, 32'h0);
            counted += len;
         end else if (pick < 7) begin
            wait_drained();
         end else begin
            nr = p_recording ? ($urandom_range(99) < 4) : ($urandom_range(99) < 30);
            pick = $urandom_range(99);
            if (pick < 40) m = p_last_mask;
            else if (pick < 65) m = p_last_mask ^ (8'h01 << $urandom_range(7));
            else if (pick < 75) m = $urandom_range(1) ? 8'hFF : 8'h00;
            else m = 8'($urandom_range(255));
            counted++;
            send_tick(m, nr, NO_LIT, 32'h0);
         end
      end
   endtask

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_log.size() == 0) begin
            errors++;
            $display("%0t: unexpected log byte: expected none, got %h last %b",
                     $time, rsp_bus.log_byte, rsp_bus.last_of_event);
         end else begin
            head_item = pending_log.pop_front();
            if (head_item.data !== rsp_bus.log_byte ||
                head_item.last !== rsp_bus.last_of_event) begin
               errors++;
               $display("%0t: log byte mismatch: expected %h last %b, got %h last %b",
                        $time, head_item.data, head_item.last,
                        rsp_bus.log_byte, rsp_bus.last_of_event);
            end
         end
      end
   end

   initial begin
      logic [15:0] limits[5];
      int i;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.input_bits = 8'h00;
      req_bus.new_run = 1'b0;
      rsp_bus.ready = 1'b0;
      csr_bus.valid = 1'b0;
      csr_bus.log_limit = 16'h0000;
      p_last_mask = 8'h00;
      p_ticks = '0;
      p_bytes = '0;
      p_recording = 1'b1;
      p_awaiting_seed = 1'b1;
      p_limit = icle_pkg::LOG_LIMIT_RESET;

      // seed, no-change, deltas at the varint byte boundary, new runs
      add_row(8'h00, 1'b0, 1, 3'd2, 32'h0000_0000);
      add_row(8'h00, 1'b0, 1, 3'd0, 32'h0);
      add_row(8'hFF, 1'b0, 1, 3'd2, 32'h02FF_0000);
      add_row(8'hFF, 1'b0, 1, 3'd0, 32'h0);
      add_row(8'hA5, 1'b0, 1, 3'd2, 32'h02A5_0000);
      add_row(8'h5A, 1'b1, 1, 3'd2, 32'h005A_0000);
      add_row(8'h5A, 1'b1, 1, 3'd2, 32'h005A_0000);
      add_row(8'h01, 1'b0, 1, 3'd2, 32'h0101_0000);
      add_row(8'h01, 1'b0, 126, NO_LIT, 32'h0);
      add_row(8'h80, 1'b0, 1, 3'd2, 32'h7F80_0000);
      add_row(8'h80, 1'b0, 127, NO_LIT, 32'h0);
      add_row(8'h02, 1'b0, 1, 3'd3, 32'h8001_0200);
      add_row(8'h00, 1'b0, 1, 3'd2, 32'h0100_0000);
      add_row(8'h7F, 1'b0, 1, 3'd2, 32'h017F_0000);
      add_row(8'h80, 1'b1, 1, 3'd2, 32'h0080_0000);
      add_row(8'h80, 1'b0, 1, 3'd0, 32'h0);
      add_row(8'h55, 1'b0, 1, 3'd2, 32'h0255_0000);
      add_row(8'hAA, 1'b0, 1, 3'd2, 32'h01AA_0000);

      limits[0] = 16'd0;
      limits[1] = 16'd7;
      limits[2] = 16'hFFFF;
      limits[3] = 16'd30;
      limits[4] = 16'($urandom_range(65535));

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[j]) begin
         repeat (dir_rows[j].reps)
            send_tick(dir_rows[j].mask, dir_rows[j].new_run, dir_rows[j].lit_n,
                      dir_rows[j].lit);
      end

      for (i = 0; i < 5; i++) begin
         wait_drained();
         write_log_limit(limits[i]);
         steady = (limits[i] == 16'hFFFF);
         run_random_ticks(ITEMS_PER_PHASE);
      end

      wait_drained();
      if (errors == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
